// File: rtl/giba_pkg.sv
package giba_pkg;

	localparam int MaxGroups = 16;
	localparam int EntriesPerGroup = 256;
	localparam int ReservedEntries = 10;
	localparam int TotalBits = MaxGroups * EntriesPerGroup;
	localparam int WordBits = 64;
	localparam int WordsPerGroup = EntriesPerGroup / WordBits;
	localparam int BitmapWords = TotalBits / WordBits;
	localparam int WordAw = $clog2(BitmapWords);
	localparam int WpgW = $clog2(WordsPerGroup);
	localparam int GrpW = 4;
	localparam int NumW = 13;
	localparam int CntW = 9;
	localparam int CfgW = 13;
	localparam int CfgIdxW = 2;

	localparam logic [CfgIdxW-1:0] CFG_GROUPS = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_FIRST = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_TOTAL = 2'd2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOFREE = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_REF = 2'd3;

	typedef struct packed {
		logic            opcode;
		logic [3:0]      start_group;
		logic            is_directory;
		logic [12:0]     entry_number;
		logic [7:0]      reference_count;
	} req_t;

	typedef struct packed {
		logic [1:0]      status;
		logic [12:0]     allocated_number;
		logic [3:0]      chosen_group;
		logic [12:0]     total_free;
	} rsp_t;

	// Classified command handed from front to back.
	typedef struct packed {
		logic            is_free;
		logic            reject;
		logic [1:0]      rej_status;
		logic [GrpW-1:0] group;
		logic [7:0]      bit_idx;
		logic            is_directory;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE, BK_GROUP, BK_READ, BK_SCAN, BK_FREE_RD, BK_FREE_WR, BK_DONE
	} bk_state_t;

endpackage

// File: rtl/giba_front.sv
module giba_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  giba_pkg::req_t                req,
	input  logic [giba_pkg::CfgW-1:0]     first_usable_entry,
	input  logic [giba_pkg::CfgW-1:0]     entry_total,
	output logic                          cmd_valid,
	input  logic                          cmd_pop,
	output giba_pkg::cmd_t                cmd
);
	localparam int Depth = 2;
	giba_pkg::cmd_t fifo_q [Depth];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	giba_pkg::cmd_t cls;
	logic [12:0] idx;
	logic        wr, rd;

	always_comb begin
		idx = req.entry_number - 13'd1;
		cls = '0;
		cls.is_free = (req.opcode == giba_pkg::OP_FREE);
		cls.group = req.start_group;
		cls.is_directory = req.is_directory;
		if (cls.is_free) begin
			cls.group = idx[11:8];
			cls.bit_idx = idx[7:0];
			if (req.reference_count > 8'd1) begin
				cls.reject = 1'b1;
				cls.rej_status = giba_pkg::ST_REF;
				cls.group = '0;
			end else if (req.entry_number == '0 || req.entry_number < first_usable_entry ||
					req.entry_number > entry_total ||
					req.entry_number > 13'(giba_pkg::TotalBits)) begin
				cls.reject = 1'b1;
				cls.rej_status = giba_pkg::ST_RANGE;
				cls.group = '0;
			end
		end
	end

	assign full = (cnt_q == 2'(Depth));
	assign wr = push && !full;
	assign rd = cmd_pop && cmd_valid;
	assign cmd_valid = (cnt_q != '0);
	assign cmd = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) fifo_q[wp_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end
endmodule

// File: rtl/giba_back.sv
module giba_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_pop,
	input  giba_pkg::cmd_t                cmd,
	input  logic [4:0]                    groups_in_use,
	input  logic [giba_pkg::CfgW-1:0]     first_usable_entry,
	input  logic [giba_pkg::CfgW-1:0]     entry_total,
	output logic                          empty,
	input  logic                          pop,
	output giba_pkg::rsp_t                rsp
);
	localparam int Aw = giba_pkg::WordAw;
	localparam int Ww = giba_pkg::WpgW;

	logic [giba_pkg::WordBits-1:0] mem [giba_pkg::BitmapWords];
	logic [giba_pkg::WordBits-1:0] rdata_q;
	logic [giba_pkg::BitmapWords-1:0] wvalid_q;

	logic [giba_pkg::CntW-1:0] gfree_q [giba_pkg::MaxGroups];
	logic [giba_pkg::CntW-1:0] gdir_q [giba_pkg::MaxGroups];
	logic [12:0] gtot_q;

	giba_pkg::bk_state_t st_q, st_d;
	giba_pkg::cmd_t cmd_q;
	logic [giba_pkg::GrpW-1:0] g_q;
	logic [giba_pkg::GrpW-1:0] gsel;
	logic [4:0]  k_q;
	logic [Ww-1:0] w_q;
	logic [Aw-1:0] raddr;
	logic        rvalid_q;
	logic [giba_pkg::WordBits-1:0] word;
	logic [4:0]  ng;
	logic        res_v_q;
	giba_pkg::rsp_t res_q;

	// First-clear search over one word.
	logic        fz_found;
	logic [5:0]  fz_pos;
	always_comb begin
		fz_found = 1'b0;
		fz_pos = '0;
		for (int i = giba_pkg::WordBits - 1; i >= 0; i--) begin
			if (!word[i]) begin
				fz_found = 1'b1;
				fz_pos = 6'(i);
			end
		end
	end

	function automatic logic [giba_pkg::WordBits-1:0] reset_word(input logic [Aw-1:0] a);
		logic [giba_pkg::WordBits-1:0] w;
		w = '0;
		for (int i = 0; i < giba_pkg::WordBits; i++)
			if (a == '0 && i < giba_pkg::ReservedEntries) w[i] = 1'b1;
		return w;
	endfunction

	assign ng = (groups_in_use > 5'(giba_pkg::MaxGroups)) ? 5'(giba_pkg::MaxGroups)
		: groups_in_use;
	// Group actually visited: a start beyond the groups in use wraps to group 0.
	assign gsel = (5'(g_q) >= ng) ? '0 : g_q;
	assign word = rvalid_q ? rdata_q : reset_word(raddr);
	assign raddr = {g_q, w_q};

	logic [12:0] cand;
	assign cand = {1'b0, g_q, w_q, fz_pos} + 13'd1;

	assign empty = !res_v_q;
	assign rsp = res_q;
	assign cmd_pop = (st_q == giba_pkg::BK_IDLE) && cmd_valid && !res_v_q;

	always_comb begin
		st_d = st_q;
		case (st_q)
			giba_pkg::BK_IDLE: begin
				if (cmd_pop) begin
					if (cmd.reject) st_d = giba_pkg::BK_DONE;
					else if (cmd.is_free) st_d = giba_pkg::BK_FREE_RD;
					else st_d = giba_pkg::BK_GROUP;
				end
			end
			giba_pkg::BK_GROUP: begin
				if (k_q >= ng) st_d = giba_pkg::BK_DONE;
				else if (gfree_q[gsel] != '0) st_d = giba_pkg::BK_READ;
			end
			giba_pkg::BK_READ: st_d = giba_pkg::BK_SCAN;
			giba_pkg::BK_SCAN: begin
				if (fz_found) st_d = giba_pkg::BK_DONE;
				else if (w_q == Ww'(giba_pkg::WordsPerGroup - 1)) st_d = giba_pkg::BK_GROUP;
				else st_d = giba_pkg::BK_READ;
			end
			giba_pkg::BK_FREE_RD: st_d = giba_pkg::BK_FREE_WR;
			giba_pkg::BK_FREE_WR: st_d = giba_pkg::BK_DONE;
			giba_pkg::BK_DONE: st_d = giba_pkg::BK_IDLE;
			default: st_d = giba_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
		if (st_q == giba_pkg::BK_SCAN && fz_found && cand >= first_usable_entry
				&& cand <= entry_total)
			mem[raddr] <= word | (64'd1 << fz_pos);
		if (st_q == giba_pkg::BK_FREE_WR && word[cmd_q.bit_idx[5:0]])
			mem[raddr] <= word & ~(64'd1 << cmd_q.bit_idx[5:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= giba_pkg::BK_IDLE;
			wvalid_q <= '0;
			rvalid_q <= 1'b0;
			for (int i = 0; i < giba_pkg::MaxGroups; i++) begin
				gfree_q[i] <= (i == 0) ? giba_pkg::CntW'(giba_pkg::EntriesPerGroup
					- giba_pkg::ReservedEntries) : giba_pkg::CntW'(giba_pkg::EntriesPerGroup);
				gdir_q[i] <= '0;
			end
			gtot_q <= 13'(giba_pkg::TotalBits - giba_pkg::ReservedEntries);
			res_v_q <= 1'b0;
			res_q <= '0;
			cmd_q <= '0;
			g_q <= '0;
			k_q <= '0;
			w_q <= '0;
		end else begin
			st_q <= st_d;
			rvalid_q <= wvalid_q[raddr];
			if (pop && res_v_q) res_v_q <= 1'b0;
			case (st_q)
				giba_pkg::BK_IDLE: begin
					if (cmd_pop) begin
						cmd_q <= cmd;
						g_q <= cmd.group;
						k_q <= '0;
						w_q <= cmd.is_free ? cmd.bit_idx[7:6] : '0;
						res_q <= '{status: cmd.rej_status, allocated_number: '0,
							chosen_group: '0, total_free: gtot_q};
					end
				end
				giba_pkg::BK_GROUP: begin
					if (k_q >= ng) begin
						res_q.status <= giba_pkg::ST_NOFREE;
						res_q.chosen_group <= '0;
					end else begin
						w_q <= '0;
						if (gfree_q[gsel] == '0) begin
							k_q <= k_q + 5'd1;
							g_q <= gsel + 4'd1;
						end else begin
							g_q <= gsel;
						end
					end
				end
				giba_pkg::BK_SCAN: begin
					if (fz_found) begin
						res_q.chosen_group <= g_q;
						if (cand < first_usable_entry || cand > entry_total) begin
							res_q.status <= giba_pkg::ST_RANGE;
						end else begin
							wvalid_q[raddr] <= 1'b1;
							res_q.status <= giba_pkg::ST_OK;
							res_q.allocated_number <= cand;
							gfree_q[g_q] <= gfree_q[g_q] - 9'd1;
							if (cmd_q.is_directory &&
									gdir_q[g_q] < 9'(giba_pkg::EntriesPerGroup))
								gdir_q[g_q] <= gdir_q[g_q] + 9'd1;
							if (gtot_q != '0) begin
								gtot_q <= gtot_q - 13'd1;
								res_q.total_free <= gtot_q - 13'd1;
							end
						end
					end else if (w_q == Ww'(giba_pkg::WordsPerGroup - 1)) begin
						k_q <= k_q + 5'd1;
						g_q <= g_q + 4'd1;
						w_q <= '0;
					end else begin
						w_q <= w_q + Ww'(1);
					end
				end
				giba_pkg::BK_FREE_WR: begin
					res_q.chosen_group <= g_q;
					if (!word[cmd_q.bit_idx[5:0]]) begin
						res_q.status <= giba_pkg::ST_RANGE;
					end else begin
						wvalid_q[raddr] <= 1'b1;
						res_q.status <= giba_pkg::ST_OK;
						if (gfree_q[g_q] < 9'(giba_pkg::EntriesPerGroup))
							gfree_q[g_q] <= gfree_q[g_q] + 9'd1;
						if (cmd_q.is_directory && gdir_q[g_q] != '0)
							gdir_q[g_q] <= gdir_q[g_q] - 9'd1;
						if (gtot_q < 13'(giba_pkg::TotalBits)) begin
							gtot_q <= gtot_q + 13'd1;
							res_q.total_free <= gtot_q + 13'd1;
						end
					end
				end
				giba_pkg::BK_DONE: res_v_q <= 1'b1;
				default: ;
			endcase
		end
	end
endmodule

// File: rtl/grouped_inode_bitmap_allocator_top.sv
// Grouped entry allocator over per-group usage bitmaps. Requests enter through a
// queue-style push/full port and results leave through an empty/pop port, one
// result beat per request, in order. The front stage classifies each request
// (reference and range checks for frees) into a two-deep command queue; the back
// stage owns the bitmap memory (64 words of 64 bits, one read port with a
// registered output) and the counters. A rejected request goes straight to its
// result; a free reads its bitmap word and writes it back; an allocate checks
// each visited group's free counter, then reads and scans bitmap words. The
// per-group free counters let the search skip full groups without reading them,
// so at most one group is scanned, one bitmap word at a time. The back stage
// holds one result and takes the next command only once that result has been
// popped. Configuration registers (index 0 groups in use, 1 first usable entry,
// 2 entry total) are written through cfg_we/cfg_index/cfg_data; the user must
// do so only while the block is idle, which the block itself does not enforce.
// The bitmap needs no clearing pass: per-word written flags make never-written
// words read as their reset contents.
module grouped_inode_bitmap_allocator_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  giba_pkg::req_t                      req,
	output logic                                empty,
	input  logic                                pop,
	output giba_pkg::rsp_t                      rsp,
	input  logic                                cfg_we,
	input  logic [giba_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [giba_pkg::CfgW-1:0]           cfg_data
);
	logic [4:0]  groups_q;
	logic [12:0] first_q, total_q;
	logic        cmd_valid, cmd_pop;
	giba_pkg::cmd_t cmd;

	// Configuration registers; writes to unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			groups_q <= 5'd16;
			first_q <= 13'd11;
			total_q <= 13'd4096;
		end else if (cfg_we) begin
			case (cfg_index)
				giba_pkg::CFG_GROUPS: groups_q <= cfg_data[4:0];
				giba_pkg::CFG_FIRST: first_q <= cfg_data;
				giba_pkg::CFG_TOTAL: total_q <= cfg_data;
				default: ;
			endcase
		end
	end

	giba_front u_front (
		.clk, .arst_n, .push, .full, .req,
		.first_usable_entry(first_q), .entry_total(total_q),
		.cmd_valid, .cmd_pop, .cmd
	);

	giba_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd_pop, .cmd,
		.groups_in_use(groups_q), .first_usable_entry(first_q), .entry_total(total_q),
		.empty, .pop, .rsp
	);
endmodule

// File: test/tb_grouped_inode_bitmap_allocator_top.sv
module tb_grouped_inode_bitmap_allocator_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Allocator scoreboard: a private copy of the bitmap, counters and
	// configuration, plus the queue of responses still owed by the block.
	class alloc_scoreboard;
		bit [giba_pkg::TotalBits-1:0] used;
		int unsigned grp_free[giba_pkg::MaxGroups];
		int unsigned grp_dirs[giba_pkg::MaxGroups];
		int unsigned free_total;
		int unsigned n_groups;
		int unsigned first_ok;
		int unsigned last_ok;
		giba_pkg::rsp_t owed[$];
		int errors;

		function void reset_state();
			used = '0;
			for (int i = 0; i < giba_pkg::MaxGroups; i++) begin
				grp_free[i] = giba_pkg::EntriesPerGroup;
				grp_dirs[i] = 0;
			end
			for (int i = 0; i < giba_pkg::ReservedEntries; i++)
				used[i] = 1'b1;
			grp_free[0] = giba_pkg::EntriesPerGroup - giba_pkg::ReservedEntries;
			free_total = giba_pkg::TotalBits - giba_pkg::ReservedEntries;
			n_groups = 16;
			first_ok = 11;
			last_ok = 4096;
			owed.delete();
			errors = 0;
		endfunction

		function void set_reg(logic [giba_pkg::CfgIdxW-1:0] idx,
				logic [giba_pkg::CfgW-1:0] val);
			if (idx == giba_pkg::CFG_GROUPS)
				n_groups = 32'(val[4:0]);
			else if (idx == giba_pkg::CFG_FIRST)
				first_ok = 32'(val);
			else if (idx == giba_pkg::CFG_TOTAL)
				last_ok = 32'(val);
		endfunction

		function giba_pkg::rsp_t make_rsp(logic [1:0] st, int unsigned num,
				int unsigned grp);
			giba_pkg::rsp_t r;
			r.status = st;
			r.allocated_number = num[12:0];
			r.chosen_group = grp[3:0];
			r.total_free = free_total[12:0];
			return r;
		endfunction

		function giba_pkg::rsp_t allocate(int unsigned start, bit dir);
			int unsigned ng, g, b, base, num;
			ng = (n_groups > giba_pkg::MaxGroups) ? giba_pkg::MaxGroups : n_groups;
			g = start;
			for (int k = 0; k < ng; k++, g++) begin
				if (g >= ng)
					g = 0;
				if (grp_free[g] == 0)
					continue;
				base = g * giba_pkg::EntriesPerGroup;
				for (b = 0; b < giba_pkg::EntriesPerGroup; b++)
					if (!used[base + b])
						break;
				if (b >= giba_pkg::EntriesPerGroup)
					continue;
				num = base + b + 1;
				if (num < first_ok || num > last_ok)
					return make_rsp(giba_pkg::ST_RANGE, 0, g);
				used[base + b] = 1'b1;
				grp_free[g]--;
				if (dir && grp_dirs[g] < giba_pkg::EntriesPerGroup)
					grp_dirs[g]++;
				if (free_total > 0)
					free_total--;
				return make_rsp(giba_pkg::ST_OK, num, g);
			end
			return make_rsp(giba_pkg::ST_NOFREE, 0, 0);
		endfunction

		function giba_pkg::rsp_t release_entry(int unsigned num, int unsigned refs, bit dir);
			int unsigned g;
			if (refs > 1)
				return make_rsp(giba_pkg::ST_REF, 0, 0);
			if (num == 0 || num < first_ok || num > last_ok || num > giba_pkg::TotalBits)
				return make_rsp(giba_pkg::ST_RANGE, 0, 0);
			g = (num - 1) / giba_pkg::EntriesPerGroup;
			if (!used[num - 1])
				return make_rsp(giba_pkg::ST_RANGE, 0, g);
			used[num - 1] = 1'b0;
			if (grp_free[g] < giba_pkg::EntriesPerGroup)
				grp_free[g]++;
			if (dir && grp_dirs[g] > 0)
				grp_dirs[g]--;
			if (free_total < giba_pkg::TotalBits)
				free_total++;
			return make_rsp(giba_pkg::ST_OK, 0, g);
		endfunction

		function void note_request(giba_pkg::req_t q);
			if (q.opcode == giba_pkg::OP_ALLOC)
				owed.push_back(allocate(32'(q.start_group), q.is_directory));
			else
				owed.push_back(release_entry(32'(q.entry_number), 32'(q.reference_count),
					q.is_directory));
		endfunction

		function void check_response(giba_pkg::rsp_t got);
			giba_pkg::rsp_t exp;
			if (owed.size() == 0) begin
				$error("response beat with nothing expected: %p", got);
				errors++;
				return;
			end
			exp = owed.pop_front();
			if (got.status !== exp.status) begin
				$error("status: expected %0d, got %0d", exp.status, got.status);
				errors++;
			end
			if (got.allocated_number !== exp.allocated_number) begin
				$error("allocated_number: expected %0d, got %0d",
					exp.allocated_number, got.allocated_number);
				errors++;
			end
			if (got.chosen_group !== exp.chosen_group) begin
				$error("chosen_group: expected %0d, got %0d",
					exp.chosen_group, got.chosen_group);
				errors++;
			end
			if (got.total_free !== exp.total_free) begin
				$error("total_free: expected %0d, got %0d",
					exp.total_free, got.total_free);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	giba_pkg::req_t req = '0;
	logic empty;
	logic pop = 1'b0;
	giba_pkg::rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [giba_pkg::CfgIdxW-1:0] cfg_index = '0;
	logic [giba_pkg::CfgW-1:0] cfg_data = '0;

	alloc_scoreboard sb;
	// When calm is set, neither side idles or stalls; it gives the long
	// stretch of back-to-back traffic.
	bit calm = 1'b0;
	// Entries we believe are allocated, used to aim frees at live entries.
	int unsigned live_entries[$];

	grouped_inode_bitmap_allocator_top u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.empty(empty), .pop(pop), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Result side: pop is changed at the falling edge only, and a response
	// beat is taken at the rising edge where pop is high and empty is low.
	always @(negedge clk)
		pop <= calm ? 1'b1 : ($urandom_range(99) >= 6);

	always @(posedge clk)
		if (arst_n && pop && !empty)
			sb.check_response(rsp);

	// Tracks allocations for later frees: the last owed response tells us
	// the entry number that the model just handed out.
	function automatic void note_live_entry();
		giba_pkg::rsp_t r;
		r = sb.owed[$];
		if (r.status == giba_pkg::ST_OK && r.allocated_number != 0)
			live_entries.push_back(32'(r.allocated_number));
	endfunction

	// Present one request and hold it until it is taken. The sender may
	// idle first, so gaps land on every stage of the block.
	// Push stays high after a beat and is dropped only for an idle cycle
	// or by drain.
	task automatic send_request(giba_pkg::req_t q);
		if (!calm)
			while ($urandom_range(99) < 6) begin
				push <= 1'b0;
				@(negedge clk);
			end
		req <= q;
		push <= 1'b1;
		do
			@(posedge clk);
		while (full);
		sb.note_request(q);
		if (q.opcode == giba_pkg::OP_ALLOC)
			note_live_entry();
		@(negedge clk);
	endtask

	task automatic send_alloc(int unsigned start, bit dir);
		giba_pkg::req_t q;
		q = '0;
		q.opcode = giba_pkg::OP_ALLOC;
		q.start_group = start[3:0];
		q.is_directory = dir;
		q.entry_number = 13'($urandom_range(8191));
		q.reference_count = 8'($urandom_range(255));
		send_request(q);
	endtask

	task automatic send_free(int unsigned num, int unsigned refs, bit dir);
		giba_pkg::req_t q;
		q = '0;
		q.opcode = giba_pkg::OP_FREE;
		q.start_group = 4'($urandom_range(15));
		q.is_directory = dir;
		q.entry_number = num[12:0];
		q.reference_count = refs[7:0];
		send_request(q);
	endtask

	// Wait for the block to drain: every owed response must arrive, and a
	// generous margin follows the last beat.
	task automatic drain();
		push <= 1'b0;
		while (sb.owed.size() != 0)
			@(negedge clk);
		repeat (200)
			@(negedge clk);
	endtask

	// Write enable stays high across consecutive writes; configure drops it.
	task automatic write_reg(logic [giba_pkg::CfgIdxW-1:0] idx, int unsigned val);
		cfg_index <= idx;
		cfg_data <= val[giba_pkg::CfgW-1:0];
		cfg_we <= 1'b1;
		@(negedge clk);
		sb.set_reg(idx, val[giba_pkg::CfgW-1:0]);
	endtask

	task automatic configure(int unsigned groups, int unsigned first, int unsigned last);
		drain();
		write_reg(giba_pkg::CFG_GROUPS, groups);
		write_reg(giba_pkg::CFG_FIRST, first);
		write_reg(giba_pkg::CFG_TOTAL, last);
		cfg_we <= 1'b0;
	endtask

	// Mostly allocate/free pairs against live entries, with some noise:
	// random numbers, bad reference counts and double frees.
	task automatic random_phase(int n);
		int unsigned pick, idx, num;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 50 || live_entries.size() == 0)
				send_alloc($urandom_range(15), 1'($urandom_range(1)));
			else if (pick < 80) begin
				idx = $urandom_range(live_entries.size() - 1);
				num = live_entries[idx];
				live_entries.delete(idx);
				send_free(num, $urandom_range(1), 1'($urandom_range(1)));
			end else if (pick < 90)
				send_free($urandom_range(8191), $urandom_range(255),
					1'($urandom_range(1)));
			else
				send_free($urandom_range(4096), $urandom_range(2, 255),
					1'($urandom_range(1)));
		end
	endtask

	initial begin
		sb = new();
		sb.reset_state();
		repeat (6)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset configuration: first allocations land
		// right after the reserved entries, then the field extremes.
		send_alloc(0, 1'b1);
		send_alloc(15, 1'b0);
		send_free(11, 0, 1'b1);
		send_free(11, 1, 1'b0);
		send_free(0, 0, 1'b0);
		send_free(4096, 1, 1'b1);
		send_free(8191, 0, 1'b0);
		send_free(5, 1, 1'b0);
		send_free(300, 255, 1'b1);
		send_free(300, 1, 1'b0);

		// Candidate below the first usable entry gives a range failure in group 0.
		configure(16, 4096, 4096);
		send_alloc(0, 1'b0);
		send_alloc(3, 1'b1);
		// Zero groups: nothing is searched.
		configure(0, 1, 4096);
		send_alloc(7, 1'b0);
		// More groups than stored, and a start beyond the groups in use.
		configure(31, 1, 4096);
		send_alloc(15, 1'b1);
		configure(1, 1, 1);
		send_alloc(9, 1'b0);
		send_alloc(0, 1'b0);
		configure(2, 1, 8191);
		send_alloc(12, 1'b1);
		send_free(4097, 1, 1'b0);

		live_entries.delete();
		configure(16, 11, 4096);

		// Fill group 1 to exercise full groups and group skipping.
		calm = 1'b1;
		for (int i = 0; i < 260; i++)
			send_alloc(1, 1'($urandom_range(1)));
		random_phase(40);
		calm = 1'b0;
		random_phase(100);

		configure(4, 1, 1100);
		random_phase(80);
		configure(16, 2000, 4096);
		random_phase(80);
		configure(3, 200, 700);
		random_phase(50);

		drain();
		if (sb.errors == 0 && sb.owed.size() == 0)
			$display("*** PASSED ***");
		else begin
			if (sb.owed.size() != 0)
				$error("%0d expected responses never arrived", sb.owed.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run of about 630 requests plus
	// stalls and the drains between phases.
	initial begin
		#2ms;
		$display("*** FAILED ***");
		$finish;
	end
endmodule

// File: filelist.f
rtl/giba_pkg.sv
rtl/giba_front.sv
rtl/giba_back.sv
rtl/grouped_inode_bitmap_allocator_top.sv
test/tb_grouped_inode_bitmap_allocator_top.sv
